// ===== rtl/coq_pkg.sv =====
// Package for the cell overvoltage qualifier: widths, qualifier and event codes,
// register indexes and the packed types shared by the RTL, the checker and the bench.
// No dependencies.
package coq_pkg;

  // Default sizing
  localparam int CELLS_DEF  = 256;
  localparam int LEVELS_DEF = 3;

  // Field widths
  localparam int CELL_W    = 8;
  localparam int LEVEL_W   = 2;
  localparam int VOLT_W    = 16;
  localparam int CNT_W     = 8;
  localparam int PARAM_W   = 48;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_REGS  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THREE = 2'd2;

  // Qualifier flag per cell and level
  typedef enum logic [1:0] {
    Q_NORMAL    = 2'd0,
    Q_SETTING   = 2'd1,
    Q_SET       = 2'd2,
    Q_RELEASING = 2'd3
  } qual_t;

  // Event kind
  typedef enum logic {
    EV_SET     = 1'b0,
    EV_RELEASE = 1'b1
  } evkind_t;

  // One level's register, MSB first
  typedef struct packed {
    logic [CNT_W-1:0]  rel_time;
    logic [CNT_W-1:0]  set_time;
    logic [VOLT_W-1:0] rel_thr;
    logic [VOLT_W-1:0] set_thr;
  } lvl_params_t;

  // One entry of the state memory
  typedef struct packed {
    qual_t            qual;
    logic [CNT_W-1:0] set_cnt;
    logic [CNT_W-1:0] rel_cnt;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{qual: Q_NORMAL, set_cnt: '0, rel_cnt: '0};

  // Outcome of one qualifier update
  typedef struct packed {
    entry_t  entry;
    logic    ev;
    evkind_t kind;
  } upd_res_t;

endpackage

// ===== rtl/coq_channels_if.sv =====
// Channel interfaces of the cell overvoltage qualifier: sample input,
// event output and configuration write. Depends on coq_pkg.
interface coq_in_if import coq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CELL_W-1:0]  cell_index;
  logic [LEVEL_W-1:0] level;
  logic [VOLT_W-1:0]  cell_voltage;

  modport source(output valid, cell_index, level, cell_voltage, input ready);
  modport sink(input valid, cell_index, level, cell_voltage, output ready);
endinterface

interface coq_out_if import coq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               event_valid;
  logic               event_kind;
  logic [LEVEL_W-1:0] event_level;
  logic [CELL_W-1:0]  event_cell;
  logic [1:0]         cell_state;

  modport source(output valid, event_valid, event_kind, event_level, event_cell,
                 cell_state, input ready);
  modport sink(input valid, event_valid, event_kind, event_level, event_cell,
               cell_state, output ready);
endinterface

interface coq_cfg_if import coq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PARAM_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/coq_cfg_regs.sv =====
// Level parameter registers of the cell overvoltage qualifier and the
// per-level select for the update stage. Depends on coq_pkg, coq_cfg_if.
module coq_cfg_regs import coq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  coq_cfg_if.sink            cfg_ch,
  input  logic [LEVEL_W-1:0] sel_level,
  output lvl_params_t        sel_params
);

  lvl_params_t params_r [NUM_REGS];

  // Always ready; writes past the last register are dropped
  assign cfg_ch.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) params_r[i] <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_LEVEL_ONE:   params_r[0] <= lvl_params_t'(cfg_ch.data);
        REG_LEVEL_TWO:   params_r[1] <= lvl_params_t'(cfg_ch.data);
        REG_LEVEL_THREE: params_r[2] <= lvl_params_t'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Parameters of the level being updated
  assign sel_params = (32'(sel_level) < NUM_REGS) ? params_r[sel_level] : '0;

endmodule

// ===== rtl/coq_state_mem.sv =====
// Qualifier state memory: one write port, one registered read port.
// Depends on coq_pkg.
module coq_state_mem import coq_pkg::*; #(
  parameter int DEPTH  = LEVELS_DEF * CELLS_DEF,
  parameter int ADDR_W = $clog2(LEVELS_DEF * CELLS_DEF)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/coq_update.sv =====
// Qualifier update for one sample: set path first, then the release path on
// the state the set path left. Depends on coq_pkg.
module coq_update import coq_pkg::*; (
  input  entry_t            cur,
  input  lvl_params_t       prm,
  input  logic [VOLT_W-1:0] volt,
  output upd_res_t          res
);

  qual_t            q_set, q_fin;
  logic [CNT_W-1:0] sc_nxt, rc_nxt;
  logic [CNT_W-1:0] sc_inc, rc_inc;
  logic             set_cond, rel_cond;
  logic             set_ev, rel_ev;

  assign sc_inc   = cur.set_cnt + CNT_W'(1);
  assign rc_inc   = cur.rel_cnt + CNT_W'(1);
  assign set_cond = (volt > prm.set_thr) && (prm.set_time != '0);
  assign rel_cond = (volt < prm.rel_thr) && (prm.rel_time != '0);

  // Set path
  always_comb begin
    q_set  = cur.qual;
    sc_nxt = cur.set_cnt;
    set_ev = 1'b0;
    if (set_cond) begin
      if (cur.qual == Q_NORMAL) begin
        q_set  = Q_SETTING;
        sc_nxt = CNT_W'(1);
      end else if (cur.qual == Q_SETTING) begin
        sc_nxt = sc_inc;
        if (sc_inc >= prm.set_time) begin
          q_set  = Q_SET;
          sc_nxt = '0;
          set_ev = 1'b1;
        end
      end
    end else if (cur.qual == Q_SETTING) begin
      q_set = Q_NORMAL;
    end
  end

  // Release path
  always_comb begin
    q_fin  = q_set;
    rc_nxt = cur.rel_cnt;
    rel_ev = 1'b0;
    if (rel_cond) begin
      if (q_set == Q_SET) begin
        q_fin  = Q_RELEASING;
        rc_nxt = CNT_W'(1);
      end else if (q_set == Q_RELEASING) begin
        rc_nxt = rc_inc;
        if (rc_inc >= prm.rel_time) begin
          q_fin  = Q_NORMAL;
          rc_nxt = '0;
          rel_ev = 1'b1;
        end
      end
    end else if (q_set == Q_RELEASING) begin
      q_fin = Q_SET;
    end
  end

  // A release event can only come from a releasing flag, so it never meets a set event
  always_comb begin
    res.entry.qual    = q_fin;
    res.entry.set_cnt = sc_nxt;
    res.entry.rel_cnt = rc_nxt;
    res.ev            = set_ev | rel_ev;
    res.kind          = rel_ev ? EV_RELEASE : EV_SET;
  end

endmodule

// ===== rtl/cell_overvoltage_qualifier_unit.sv =====
// Top level of the cell overvoltage qualifier.
// Depends on coq_pkg, coq_channels_if, coq_cfg_regs, coq_state_mem, coq_update.
//
// Debounces overvoltage per cell and protection level. Takes one sample per
// clock while the output is not stalled, and returns exactly one result per
// sample through the state memory read register, then the update and write
// back into the output register. The rate is set by the single read-modify-write
// on the state memory; a sample that hits the last written-back entry takes the
// forwarded value. After reset the block clears all LEVELS*CELLS entries of
// the state memory (768 at the defaults) with in_ch.ready low; configuration
// writes are taken at all times. Samples with a level or cell index out of
// range change nothing and return an all-zero result.
module cell_overvoltage_qualifier_unit import coq_pkg::*; #(
  parameter int CELLS  = CELLS_DEF,
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  coq_in_if.sink    in_ch,
  coq_out_if.source out_ch,
  coq_cfg_if.sink   cfg_ch
);

  localparam int DEPTH  = LEVELS * CELLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Clearing pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Input side
  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;

  // Update stage
  logic               s1_valid_r;
  logic               s1_in_range_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [CELL_W-1:0]  s1_cell_r;
  logic [LEVEL_W-1:0] s1_level_r;
  logic [VOLT_W-1:0]  s1_volt_r;
  logic               s1_fire;

  // Forwarding of the last write
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  entry_t            fwd_entry_r;

  // Memory and update
  entry_t            rd_entry;
  entry_t            cur_entry;
  lvl_params_t       s1_params;
  upd_res_t          upd;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  // Output register
  logic               out_valid_r;
  logic               ev_valid_r;
  logic               ev_kind_r;
  logic [LEVEL_W-1:0] ev_level_r;
  logic [CELL_W-1:0]  ev_cell_r;
  logic [1:0]         state_r;

  // Input handshake and address
  assign accept   = in_ch.valid & in_ch.ready;
  assign in_range = (32'(in_ch.level) < LEVELS) && (32'(in_ch.cell_index) < CELLS);
  assign in_addr  = ADDR_W'(ADDR_W'(in_ch.level) * ADDR_W'(CELLS) +
                            ADDR_W'(in_ch.cell_index));
  assign s1_fire  = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~clearing_r & (~s1_valid_r | s1_fire);

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) clearing_r <= 1'b0;
    end
  end

  // Update stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Update stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_range_r <= in_range;
      s1_addr_r     <= in_addr;
      s1_cell_r     <= in_ch.cell_index;
      s1_level_r    <= in_ch.level;
      s1_volt_r     <= in_ch.cell_voltage;
    end
  end

  coq_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .sel_level  (s1_level_r),
    .sel_params (s1_params)
  );

  coq_state_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept & in_range),
    .rd_addr (in_addr),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Read data, or the last written-back entry, which the read may have missed
  assign cur_entry = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_entry_r : rd_entry;

  coq_update u_upd (
    .cur  (cur_entry),
    .prm  (s1_params),
    .volt (s1_volt_r),
    .res  (upd)
  );

  // Write port: clearing pass or write back
  always_comb begin
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = ENTRY_RESET;
    end else begin
      wr_en   = s1_fire & s1_in_range_r;
      wr_addr = s1_addr_r;
      wr_data = upd.entry;
    end
  end

  // Forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_fire && s1_in_range_r) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_in_range_r) begin
      fwd_addr_r  <= s1_addr_r;
      fwd_entry_r <= upd.entry;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload; fields are zero where nothing happened
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (s1_in_range_r) begin
        ev_valid_r <= upd.ev;
        ev_kind_r  <= upd.ev ? upd.kind : EV_SET;
        ev_level_r <= upd.ev ? s1_level_r : '0;
        ev_cell_r  <= upd.ev ? s1_cell_r : '0;
        state_r    <= upd.entry.qual;
      end else begin
        ev_valid_r <= 1'b0;
        ev_kind_r  <= EV_SET;
        ev_level_r <= '0;
        ev_cell_r  <= '0;
        state_r    <= Q_NORMAL;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_valid = ev_valid_r;
  assign out_ch.event_kind  = ev_kind_r;
  assign out_ch.event_level = ev_level_r;
  assign out_ch.event_cell  = ev_cell_r;
  assign out_ch.cell_state  = state_r;

endmodule

// ===== rtl/coq_checker.sv =====
// Port-level checker for the cell overvoltage qualifier and its bind to the
// top level. Depends on coq_pkg and cell_overvoltage_qualifier_unit.
module coq_checker import coq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               event_valid,
  input logic               event_kind,
  input logic [LEVEL_W-1:0] event_level,
  input logic [CELL_W-1:0]  event_cell,
  input logic [1:0]         cell_state
);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(event_valid) && $stable(event_kind) &&
      $stable(event_level) && $stable(event_cell) && $stable(cell_state))
    else $error("result payload changed while stalled");

  // No event: the event fields are zero
  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !event_valid |-> event_kind == EV_SET && event_level == '0 &&
      event_cell == '0)
    else $error("event fields set without an event");

  // Event kind agrees with the flag it leaves behind
  a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_valid |->
      (event_kind == EV_RELEASE && cell_state == Q_NORMAL) ||
      (event_kind == EV_SET && (cell_state == Q_SET || cell_state == Q_RELEASING)))
    else $error("event kind does not match the qualifier state");

  // State memory clearing holds off samples right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("samples taken before the state memory was cleared");

endmodule

bind cell_overvoltage_qualifier_unit coq_checker u_coq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .event_valid (out_ch.event_valid),
  .event_kind  (out_ch.event_kind),
  .event_level (out_ch.event_level),
  .event_cell  (out_ch.event_cell),
  .cell_state  (out_ch.cell_state)
);

// ===== bench/cell_overvoltage_qualifier_unit_tb.sv =====
// Self-checking bench for cell_overvoltage_qualifier_unit: drives voltage samples,
// level register writes and back-pressure, and checks every event result.
// Depends on coq_pkg, coq_channels_if and cell_overvoltage_qualifier_unit from the RTL.
`timescale 1ns / 100ps

module cell_overvoltage_qualifier_unit_tb;
  import coq_pkg::*;

  // One voltage sample as offered on the input channel
  typedef struct packed {
    logic [CELL_W-1:0]  cell_index;
    logic [LEVEL_W-1:0] level;
    logic [VOLT_W-1:0]  cell_voltage;
  } sample_t;

  // One result of the qualifier
  typedef struct packed {
    logic               event_valid;
    evkind_t            event_kind;
    logic [LEVEL_W-1:0] event_level;
    logic [CELL_W-1:0]  event_cell;
    qual_t              cell_state;
  } qual_event_t;

  logic clk;
  logic rst_n;

  coq_in_if  in_ch ();
  coq_out_if out_ch ();
  coq_cfg_if cfg_ch ();

  cell_overvoltage_qualifier_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the level registers and of the per-cell qualifier memory
  lvl_params_t      level_cfg [NUM_REGS];
  qual_t            qual_mem [LEVELS_DEF][CELLS_DEF];
  logic [CNT_W-1:0] set_cnt_mem [LEVELS_DEF][CELLS_DEF];
  logic [CNT_W-1:0] rel_cnt_mem [LEVELS_DEF][CELLS_DEF];

  sample_t     sample_queue[$];
  qual_event_t pending_events[$];

  bit sample_taken;
  bit idle_on;
  int hold_left;
  int mismatch_count;

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Debounce update of one cell/level entry; returns the expected result
  function automatic qual_event_t qualify_sample(sample_t s);
    qual_event_t      r;
    lvl_params_t      p;
    qual_t            q;
    logic [CNT_W-1:0] sc;
    logic [CNT_W-1:0] rc;
    r = '0;
    if (s.level >= LEVEL_W'(LEVELS_DEF)) return r;
    p  = level_cfg[s.level];
    q  = qual_mem[s.level][s.cell_index];
    sc = set_cnt_mem[s.level][s.cell_index];
    rc = rel_cnt_mem[s.level][s.cell_index];

    // set path first
    if (s.cell_voltage > p.set_thr && p.set_time != '0) begin
      if (q == Q_NORMAL) begin
        q  = Q_SETTING;
        sc = 8'd1;
      end else if (q == Q_SETTING) begin
        sc = sc + 8'd1;
        if (sc >= p.set_time) begin
          q  = Q_SET;
          sc = '0;
          r.event_valid = 1'b1;
          r.event_kind  = EV_SET;
        end
      end
    end else if (q == Q_SETTING) begin
      q = Q_NORMAL;
    end

    // release path sees what the set path left
    if (s.cell_voltage < p.rel_thr && p.rel_time != '0) begin
      if (q == Q_SET) begin
        q  = Q_RELEASING;
        rc = 8'd1;
      end else if (q == Q_RELEASING) begin
        rc = rc + 8'd1;
        if (rc >= p.rel_time) begin
          q  = Q_NORMAL;
          rc = '0;
          r.event_valid = 1'b1;
          r.event_kind  = EV_RELEASE;
        end
      end
    end else if (q == Q_RELEASING) begin
      q = Q_SET;
    end

    qual_mem[s.level][s.cell_index]    = q;
    set_cnt_mem[s.level][s.cell_index] = sc;
    rel_cnt_mem[s.level][s.cell_index] = rc;
    if (r.event_valid) begin
      r.event_level = s.level;
      r.event_cell  = s.cell_index;
    end
    r.cell_state = q;
    return r;
  endfunction

  // Sample driver: new transaction at the falling edge once the last one was taken
  always @(negedge clk) begin : drive_samples
    sample_t nxt;
    if (!in_ch.valid || sample_taken) begin
      if (sample_queue.size() != 0 && !(idle_on && $urandom_range(0, 99) < 14)) begin
        nxt = sample_queue.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.cell_index   <= nxt.cell_index;
        in_ch.level        <= nxt.level;
        in_ch.cell_voltage <= nxt.cell_voltage;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Accepted samples feed the predictor
  always @(posedge clk) begin : watch_samples
    sample_t s;
    sample_taken = in_ch.valid && in_ch.ready;
    if (sample_taken) begin
      s.cell_index   = in_ch.cell_index;
      s.level        = in_ch.level;
      s.cell_voltage = in_ch.cell_voltage;
      pending_events.push_back(qualify_sample(s));
    end
  end

  // Result receiver: random stalls plus a counted long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(0, 99) < 14);
    end
  end

  // Result checker
  always @(posedge clk) begin : check_events
    qual_event_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        $error("result transaction with no expected result");
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_ch.event_valid !== want.event_valid) begin
          $error("event_valid: expected %0d, actual %0d", want.event_valid,
                 out_ch.event_valid);
          mismatch_count++;
        end
        if (out_ch.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, actual %0d", want.event_kind,
                 out_ch.event_kind);
          mismatch_count++;
        end
        if (out_ch.event_level !== want.event_level) begin
          $error("event_level: expected %0d, actual %0d", want.event_level,
                 out_ch.event_level);
          mismatch_count++;
        end
        if (out_ch.event_cell !== want.event_cell) begin
          $error("event_cell: expected %0d, actual %0d", want.event_cell,
                 out_ch.event_cell);
          mismatch_count++;
        end
        if (out_ch.cell_state !== want.cell_state) begin
          $error("cell_state: expected %0d, actual %0d", want.cell_state,
                 out_ch.cell_state);
          mismatch_count++;
        end
      end
    end
  end

  task automatic push_sample(int cell_num, int lvl, int volt);
    sample_t s;
    s.cell_index   = CELL_W'(cell_num);
    s.level        = LEVEL_W'(lvl);
    s.cell_voltage = VOLT_W'(volt);
    sample_queue.push_back(s);
  endtask

  // One level register write; the shadow follows on acceptance
  task automatic write_level(logic [CFG_IDX_W-1:0] idx, lvl_params_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    level_cfg[idx] = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_levels(lvl_params_t p_one, lvl_params_t p_two,
                              lvl_params_t p_three);
    write_level(REG_LEVEL_ONE, p_one);
    write_level(REG_LEVEL_TWO, p_two);
    write_level(REG_LEVEL_THREE, p_three);
  endtask

  // Block is idle once nothing is queued, offered or outstanding
  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_ch.valid || pending_events.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic lvl_params_t random_level();
    lvl_params_t p;
    p.set_thr  = VOLT_W'($urandom);
    p.rel_thr  = VOLT_W'($urandom);
    p.set_time = ($urandom_range(0, 7) == 0) ? '0 : CNT_W'($urandom_range(1, 6));
    p.rel_time = ($urandom_range(0, 7) == 0) ? '0 : CNT_W'($urandom_range(1, 6));
    return p;
  endfunction

  // Runs of above-set / below-release samples on a few busy cells, with noise
  task automatic queue_random(int count);
    int          run_len;
    int          run_kind;
    int          lvl;
    int          cell_num;
    int          volt;
    lvl_params_t p;
    while (count > 0) begin
      lvl      = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
      cell_num = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, 5);
      p    = level_cfg[(lvl < LEVELS_DEF) ? lvl : 0];
      run_len  = $urandom_range(1, 10);
      run_kind = $urandom_range(0, 99);
      for (int i = 0; i < run_len; i++) begin
        if (run_kind >= 85 || $urandom_range(0, 9) == 0) begin
          volt = $urandom_range(0, 65535);
        end else if (run_kind < 45) begin
          volt = (p.set_thr == '1) ? $urandom_range(0, 65535)
                                   : $urandom_range(int'(p.set_thr) + 1, 65535);
        end else begin
          volt = (p.rel_thr == '0) ? $urandom_range(0, 65535)
                                   : $urandom_range(0, int'(p.rel_thr) - 1);
        end
        push_sample(cell_num, lvl, volt);
        if (lvl < LEVELS_DEF) count--;
      end
    end
  endtask

  // Run limit
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cell_index   = '0;
    in_ch.level        = '0;
    in_ch.cell_voltage = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    sample_taken   = 1'b0;
    idle_on        = 1'b1;
    hold_left      = 0;
    mismatch_count = 0;
    for (int i = 0; i < NUM_REGS; i++) level_cfg[i] = '0;
    for (int l = 0; l < LEVELS_DEF; l++) begin
      for (int c = 0; c < CELLS_DEF; c++) begin
        qual_mem[l][c]    = Q_NORMAL;
        set_cnt_mem[l][c] = '0;
        rel_cnt_mem[l][c] = '0;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values of the level registers: both paths disabled
    push_sample(0, 0, 65535);
    push_sample(1, 1, 65535);
    push_sample(2, 2, 0);
    push_sample(3, 3, 12345);
    wait_drained();

    // directed: level one debounces in two samples, level two has set disabled,
    // level three has overlapping thresholds so set and release start together
    write_levels('{rel_time: 8'd2, set_time: 8'd2, rel_thr: 16'd500, set_thr: 16'd1000},
                 '{rel_time: 8'd3, set_time: 8'd0, rel_thr: 16'hFFFF, set_thr: 16'd0},
                 '{rel_time: 8'd1, set_time: 8'd1, rel_thr: 16'd200, set_thr: 16'd100});
    push_sample(0, 0, 65535);     // normal -> setting
    push_sample(0, 0, 65535);     // set event
    push_sample(0, 0, 0);         // releasing
    push_sample(0, 0, 1000);      // broken release run, back to set
    push_sample(0, 0, 0);
    push_sample(0, 0, 0);         // release event
    push_sample(255, 0, 1001);    // just above threshold
    push_sample(255, 0, 1000);    // equal to threshold breaks the run
    push_sample(255, 0, 1001);
    push_sample(255, 0, 65535);   // set event on the top cell
    push_sample(7, 1, 65535);     // set path disabled
    push_sample(7, 1, 0);
    push_sample(3, 3, 65535);     // out-of-range level ignored
    push_sample(3, 3, 0);
    push_sample(9, 2, 150);       // setting
    push_sample(9, 2, 150);       // set event, release run starts same sample
    push_sample(9, 2, 150);       // release event
    push_sample(9, 2, 50);
    push_sample(255, 2, 65535);
    push_sample(128, 0, 32768);
    wait_drained();

    // counters at full width: 255-sample set run, then 255-sample release run,
    // both sides running without idle cycles
    idle_on = 1'b0;
    write_levels('0, '{rel_time: 8'd255, set_time: 8'd255, rel_thr: 16'd0, set_thr: 16'd0},
                 '1);
    for (int i = 0; i < 256; i++) push_sample(200, 1, $urandom_range(1, 65535));
    wait_drained();
    write_levels('1, '1, '0);
    for (int i = 0; i < 256; i++) push_sample(200, 1, $urandom_range(0, 65534));
    wait_drained();

    // random phases, each under fresh register values
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) write_levels('0, '0, '0);
      else write_levels(random_level(), random_level(), random_level());
      idle_on = (ph != 0);
      if (ph == 2) hold_left = 300;
      queue_random(35);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
